FILE: sv/tcw_pkg.sv
// Shared types, command codes and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int MAX_ROW_W   = 7;
    localparam int MAX_COL_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  NEWLINE_CHAR  = 8'd10;
    localparam logic [7:0]  BLANK_CHAR    = 8'h20;
    localparam logic [7:0]  DEFAULT_COLOR = 8'h07;
    localparam logic [15:0] BLANK_CELL    = {DEFAULT_COLOR, BLANK_CHAR};

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_SETCUR = 2'd3;

    typedef enum logic [2:0] {
        OP_PUT       = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_READ      = 3'd2,
        OP_READ_NONE = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_SETCUR    = 3'd5
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [7:0]             ch;
        logic [MAX_ROW_W-1:0]   row;
        logic [MAX_COL_W-1:0]   col;
    } t_op;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [4:0] row_sel;
        logic [6:0] col_sel;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_location;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_out_word;

endpackage

`default_nettype wire

FILE: sv/tcw_front.sv
// Front end: accepts input words and classifies them into operations.
`default_nettype none

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    input  wire logic     i_init_busy,
    output logic          o_push,
    output t_op           o_op,
    input  wire logic     i_q_ready
);

    logic r_valid;
    t_op  r_op;
    t_op  op_class;
    logic accept;
    logic row_ok;
    logic col_ok;

    assign row_ok = int'(i_in_word.row_sel) < ROWS;
    assign col_ok = int'(i_in_word.col_sel) < COLUMNS;

    always_comb begin
        op_class.kind = OP_PUT;
        op_class.ch   = i_in_word.char_code;
        op_class.row  = MAX_ROW_W'(i_in_word.row_sel);
        op_class.col  = MAX_COL_W'(i_in_word.col_sel);
        unique case (i_in_word.cmd)
            CMD_PUT: begin
                op_class.kind = (i_in_word.char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            end
            CMD_READ: begin
                op_class.kind = (row_ok && col_ok) ? OP_READ : OP_READ_NONE;
            end
            CMD_CLEAR: begin
                op_class.kind = OP_CLEAR;
            end
            CMD_SETCUR: begin
                op_class.kind = OP_SETCUR;
                if (!row_ok) begin
                    op_class.row = MAX_ROW_W'(ROWS - 1);
                end
                if (!col_ok) begin
                    op_class.col = MAX_COL_W'(COLUMNS - 1);
                end
            end
            default: begin
                op_class.kind = OP_PUT;
            end
        endcase
    end

    assign o_in_stall = i_init_busy || (r_valid && !i_q_ready);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid;
    assign o_op       = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (r_valid && i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= op_class;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_queue.sv
// Short operation queue between the front end and the back end.
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_ready,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    t_op            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CNW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_ready = r_cnt != CNW'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_slot[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_back.sv
// Back end: screen memory, cursor, clear and scroll sweeps, result register.
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_text_color,
    input  wire logic       i_q_valid,
    input  wire t_op        i_q_op,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out_word,
    output logic            o_init_busy
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_COPY  = 7'b0001000,
        S_BLANK = 7'b0010000,
        S_READ  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [AW-1:0]  r_addr, n_addr;
    logic           r_scr, n_scr;
    logic           r_wr_pend, n_wr_pend;
    logic [AW-1:0]  r_wr_addr, n_wr_addr;
    logic [15:0]    r_rd_data;
    logic [15:0]    r_screen [CELLS];
    logic           r_out_valid;
    t_out_word      r_out;

    logic           slot_free;
    logic           pop;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [15:0]    mem_wd;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;
    logic           out_load;
    logic [15:0]    out_cell;
    logic           out_scr;
    logic [AW-1:0]  out_loc;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(COLUMNS) + AW'(col);
    endfunction

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign pop         = (r_state == S_IDLE) && i_q_valid && slot_free;
    assign o_q_pop     = pop;
    assign o_init_busy = r_state == S_INIT;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_addr    = r_addr;
        n_scr     = r_scr;
        n_wr_pend = 1'b0;
        n_wr_addr = r_wr_addr;
        mem_we    = r_wr_pend;
        mem_wa    = r_wr_addr;
        mem_wd    = r_rd_data;
        mem_re    = 1'b0;
        mem_ra    = r_addr;
        out_load  = 1'b0;
        out_cell  = '0;
        out_scr   = 1'b0;
        unique case (r_state) inside
            S_INIT, S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = BLANK_CELL;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_EMIT;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    unique case (i_q_op.kind) inside
                        OP_PUT, OP_NEWLINE: begin
                            if (i_q_op.kind == OP_PUT) begin
                                mem_we = 1'b1;
                                mem_wa = cell_addr(r_row, r_col);
                                mem_wd = {i_text_color, i_q_op.ch};
                            end
                            if (i_q_op.kind == OP_PUT && r_col != CW'(COLUMNS - 1)) begin
                                n_col    = r_col + 1'b1;
                                out_load = 1'b1;
                            end else begin
                                n_col = '0;
                                if (r_row == RW'(ROWS - 1)) begin
                                    n_addr  = AW'(COLUMNS);
                                    n_state = S_COPY;
                                end else begin
                                    n_row    = r_row + 1'b1;
                                    out_load = 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            mem_re  = 1'b1;
                            mem_ra  = cell_addr(RW'(i_q_op.row), CW'(i_q_op.col));
                            n_state = S_READ;
                        end
                        OP_READ_NONE: begin
                            out_load = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_addr  = '0;
                            n_state = S_FILL;
                        end
                        OP_SETCUR: begin
                            n_row    = RW'(i_q_op.row);
                            n_col    = CW'(i_q_op.col);
                            out_load = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY: begin
                mem_re    = 1'b1;
                mem_ra    = r_addr;
                n_wr_pend = 1'b1;
                n_wr_addr = r_addr - AW'(COLUMNS);
                if (r_addr == AW'(CELLS - 1)) begin
                    n_addr  = AW'(CELLS - COLUMNS);
                    n_state = S_BLANK;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_BLANK: begin
                if (!r_wr_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_addr;
                    mem_wd = {i_text_color, BLANK_CHAR};
                    if (r_addr == AW'(CELLS - 1)) begin
                        n_addr  = '0;
                        n_scr   = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            S_READ: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_cell = r_rd_data;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_scr  = r_scr;
                    n_scr    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign out_loc = cell_addr(n_row, n_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_scr       <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_addr    <= n_addr;
            r_scr     <= n_scr;
            r_wr_pend <= n_wr_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        if (out_load) begin
            r_out.cursor_row      <= 5'(n_row);
            r_out.cursor_col      <= 7'(n_col);
            r_out.cursor_location <= 11'(out_loc);
            r_out.cell_data       <= out_cell;
            r_out.scrolled        <= out_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_screen[mem_ra];
        end
    end

endmodule

`default_nettype wire

FILE: sv/text_console_writer_core.sv
// Top level of the text console writer: colour register, front end, queue, back end.
// Throughput: one word a cycle for put, newline and set cursor unless the output stalls;
// clear and scroll sweep the screen memory one cell a cycle through its single write port.
// Reset: synchronous, then a clearing pass over every cell with input stalled.
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out_word,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_text_color;
    logic       init_busy;
    logic       push;
    t_op        front_op;
    logic       q_ready;
    logic       q_valid;
    t_op        q_op;
    logic       q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= DEFAULT_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_color <= i_cfg_data;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_op        (front_op),
        .i_q_ready   (q_ready)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_q_valid    (q_valid),
        .i_q_op       (q_op),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .o_init_busy  (init_busy)
    );

`ifndef NO_ASSERTIONS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.scrolled |->
            o_out_word.cursor_col == 7'd0 &&
            o_out_word.cursor_location == 11'((ROWS - 1) * COLUMNS))
        else $error("scroll left cursor off the start of the bottom row");

    a_read_no_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.cell_data != 16'd0 |-> !o_out_word.scrolled)
        else $error("cell data and scroll flag in the same word");

    a_init_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input taken during clearing pass");
`endif

endmodule

`default_nettype wire
